FILE: rtl/can_error_status_event_generator_defines.svh
// ----------------------------------------------------------------------------
// CAN error status event generator - assertion macros
// Shared property shorthands for the block's RTL checks.
// ----------------------------------------------------------------------------
`ifndef CAN_ERROR_STATUS_EVENT_GENERATOR_DEFINES_SVH
`define CAN_ERROR_STATUS_EVENT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CESG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CESG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cesg_pkg.sv
// ----------------------------------------------------------------------------
// cesg_pkg
// Types, codes and helpers shared by the CAN error status event generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cesg_pkg;

   localparam int CNT_W   = 8;
   localparam int LEC_W   = 3;
   localparam int STATE_W = 2;
   localparam int KIND_W  = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // bus states
   localparam logic [STATE_W-1:0] ST_ACTIVE  = 2'd0;
   localparam logic [STATE_W-1:0] ST_WARNING = 2'd1;
   localparam logic [STATE_W-1:0] ST_PASSIVE = 2'd2;
   localparam logic [STATE_W-1:0] ST_BUSOFF  = 2'd3;
   // stored state, one bit wider to hold "none recorded"
   localparam logic [STATE_W:0]   ST_NONE    = 3'd4;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_STATE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COUNTS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUSERR = 2'd2;

   // last error codes / error kinds
   localparam logic [LEC_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [LEC_W-1:0] ERR_STUFF   = 3'd1;
   localparam logic [LEC_W-1:0] ERR_FORM    = 3'd2;
   localparam logic [LEC_W-1:0] ERR_ACK     = 3'd3;
   localparam logic [LEC_W-1:0] ERR_BIT1    = 3'd4;
   localparam logic [LEC_W-1:0] ERR_BIT0    = 3'd5;
   localparam logic [LEC_W-1:0] ERR_CRC     = 3'd6;
   localparam logic [LEC_W-1:0] ERR_UNKNOWN = 3'd7;

   // one classified snapshot, as queued between front and back
   typedef struct packed {
      logic               state_evt;
      logic               cnt_evt;
      logic               err_evt;
      logic [STATE_W-1:0] link_state;
      logic [CNT_W-1:0]   rx;
      logic [CNT_W-1:0]   tx;
      logic               in_tx;
      logic [LEC_W-1:0]   err_kind;
   } cmd_type;

   function automatic logic [LEC_W-1:0] map_error_kind(input logic [LEC_W-1:0] code);
      logic [LEC_W-1:0] kind;
      unique case (code)
         ERR_NONE:  kind = ERR_NONE;
         ERR_STUFF: kind = ERR_STUFF;
         ERR_FORM:  kind = ERR_FORM;
         ERR_ACK:   kind = ERR_ACK;
         ERR_BIT1:  kind = ERR_BIT1;
         ERR_BIT0:  kind = ERR_BIT0;
         ERR_CRC:   kind = ERR_CRC;
         default:   kind = ERR_UNKNOWN;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cesg_front.sv
// ----------------------------------------------------------------------------
// cesg_front
// Takes status snapshots, derives the bus state, compares against the
// stored state and builds the event command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cesg_front
   import cesg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             action,
   input  wire logic             bus_off_flag,
   input  wire logic             passive_flag,
   input  wire logic             warning_flag,
   input  wire logic [CNT_W-1:0] rx_error_count,
   input  wire logic [CNT_W-1:0] tx_error_count,
   input  wire logic [LEC_W-1:0] last_error_code,
   input  wire logic             transmitting,
   output cmd_type               cmd,
   output logic                  cmd_push
);

   logic [STATE_W:0]   prev_state_ff, prev_state_in;
   logic [CNT_W-1:0]   prev_rx_ff, prev_rx_in;
   logic [CNT_W-1:0]   prev_tx_ff, prev_tx_in;
   logic [STATE_W-1:0] cur_state;

   always_comb begin
      priority if (bus_off_flag) begin
         cur_state = ST_BUSOFF;
      end else if (passive_flag) begin
         cur_state = ST_PASSIVE;
      end else if (warning_flag) begin
         cur_state = ST_WARNING;
      end else begin
         cur_state = ST_ACTIVE;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.state_evt  = {1'b0, cur_state} != prev_state_ff;
      cmd.cnt_evt    = (rx_error_count != prev_rx_ff) || (tx_error_count != prev_tx_ff);
      cmd.err_evt    = last_error_code != ERR_NONE;
      cmd.link_state = cur_state;
      cmd.rx         = rx_error_count;
      cmd.tx         = tx_error_count;
      cmd.in_tx      = transmitting;
      cmd.err_kind   = map_error_kind(last_error_code);
   end

   assign cmd_push = accept && !action && (cmd.state_evt || cmd.cnt_evt || cmd.err_evt);

   always_comb begin
      prev_state_in = prev_state_ff;
      prev_rx_in    = prev_rx_ff;
      prev_tx_in    = prev_tx_ff;
      if (accept) begin
         if (action) begin
            prev_state_in = ST_NONE;
            prev_rx_in    = '0;
            prev_tx_in    = '0;
         end else begin
            prev_state_in = {1'b0, cur_state};
            prev_rx_in    = rx_error_count;
            prev_tx_in    = tx_error_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_state_ff <= ST_NONE;
         prev_rx_ff    <= '0;
         prev_tx_ff    <= '0;
      end else begin
         prev_state_ff <= prev_state_in;
         prev_rx_ff    <= prev_rx_in;
         prev_tx_ff    <= prev_tx_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cesg_queue.sv
// ----------------------------------------------------------------------------
// cesg_queue
// Short command queue decoupling the front end from the event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_error_status_event_generator_defines.svh"

module cesg_queue
   import cesg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_data,
   output logic          full,
   input  wire logic     pop,
   output cmd_type       head,
   output logic          head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   cmd_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W_Q'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CESG_ASSERT_IMP(a_no_overflow, clock, reset, push, !full || pop, "queue overflow")
   `CESG_ASSERT_IMP(a_no_underflow, clock, reset, pop, head_valid, "queue underflow")
   `CESG_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W_Q'(DEPTH),
                    "count beyond depth")
   `CESG_ASSERT_IMP(a_entry_has_event, clock, reset, head_valid,
                    head.state_evt || head.cnt_evt || head.err_evt,
                    "queued entry without event")

endmodule

`default_nettype wire

FILE: rtl/cesg_back.sv
// ----------------------------------------------------------------------------
// cesg_back
// Event sequencer: walks the queue head's pending events in order and emits
// one result per cycle while pop is high, via a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_error_status_event_generator_defines.svh"

module cesg_back
   import cesg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             head,
   input  wire logic                head_valid,
   output logic                     head_pop,
   input  wire logic                pop,
   output logic                     empty,
   output logic [KIND_W-1:0]        rsp_event_kind,
   output logic [STATE_W-1:0]       rsp_bus_state,
   output logic [CNT_W-1:0]         rsp_rx_errors,
   output logic [CNT_W-1:0]         rsp_tx_errors,
   output logic                     rsp_error_in_tx,
   output logic [LEC_W-1:0]         rsp_error_kind,
   output logic                     rsp_last
);

   logic [2:0]          done_ff, done_in;
   logic                out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [STATE_W-1:0]  state_ff, state_in;
   logic [CNT_W-1:0]    rx_ff, rx_in;
   logic [CNT_W-1:0]    tx_ff, tx_in;
   logic                in_tx_ff, in_tx_in;
   logic [LEC_W-1:0]    ekind_ff, ekind_in;
   logic                last_ff, last_in;
   logic [2:0]          flags;
   logic [2:0]          pending;
   logic [2:0]          sel;
   logic                next_last;
   logic                load;

   // bit 0 state, bit 1 counters, bit 2 bus error
   assign flags     = {head.err_evt, head.cnt_evt, head.state_evt};
   assign pending   = flags & ~done_ff;
   assign sel[0]    = pending[0];
   assign sel[1]    = pending[1] && !pending[0];
   assign sel[2]    = pending[2] && (pending[1:0] == 2'b00);
   assign next_last = (pending & ~sel) == 3'b000;
   assign load      = head_valid && (!out_valid_ff || pop);
   assign head_pop  = load && next_last;

   always_comb begin
      done_in      = done_ff;
      out_valid_in = out_valid_ff && !pop;
      kind_in      = kind_ff;
      state_in     = state_ff;
      rx_in        = rx_ff;
      tx_in        = tx_ff;
      in_tx_in     = in_tx_ff;
      ekind_in     = ekind_ff;
      last_in      = last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         done_in      = next_last ? 3'b000 : (done_ff | sel);
         last_in      = next_last;
         state_in     = '0;
         rx_in        = '0;
         tx_in        = '0;
         in_tx_in     = 1'b0;
         ekind_in     = ERR_NONE;
         priority if (sel[0]) begin
            kind_in  = KIND_STATE;
            state_in = head.link_state;
         end else if (sel[1]) begin
            kind_in = KIND_COUNTS;
            rx_in   = head.rx;
            tx_in   = head.tx;
         end else begin
            kind_in  = KIND_BUSERR;
            in_tx_in = head.in_tx;
            ekind_in = head.err_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      state_ff <= state_in;
      rx_ff    <= rx_in;
      tx_ff    <= tx_in;
      in_tx_ff <= in_tx_in;
      ekind_ff <= ekind_in;
      last_ff  <= last_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_bus_state   = state_ff;
   assign rsp_rx_errors   = rx_ff;
   assign rsp_tx_errors   = tx_ff;
   assign rsp_error_in_tx = in_tx_ff;
   assign rsp_error_kind  = ekind_ff;
   assign rsp_last        = last_ff;

   `CESG_ASSERT_IMP(a_done_needs_head, clock, reset, done_ff != 3'b000, head_valid,
                    "progress mask without head")
   `CESG_ASSERT_IMP(a_done_within_head, clock, reset, head_valid,
                    (done_ff & ~flags) == 3'b000, "progress mask outside head events")
   `CESG_ASSERT_IMP(a_buserr_is_last, clock, reset,
                    !empty && (rsp_event_kind == KIND_BUSERR), rsp_last,
                    "bus error event not last")
   `CESG_ASSERT_NXT(a_load_shows, clock, reset, load, !empty, "loaded event not shown")

endmodule

`default_nettype wire

FILE: rtl/can_error_status_event_generator.sv
// ----------------------------------------------------------------------------
// can_error_status_event_generator
// CAN controller error state reporting: turns status snapshots into events.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive req_* and push; a snapshot is
//   taken on a clock edge with push high and full low. req_action = 1 clears
//   the stored bus state and counters and gives no events.
//   Result side is a queue read port: while empty is low the oldest event is
//   on rsp_*; it is taken on an edge with pop high. Each snapshot gives 0 to
//   3 events (bus state, counters, bus error, in that order), rsp_last on
//   the final one.
//   A snapshot goes into the command queue (QUEUE_DEPTH entries); its events
//   leave via the registered output stage. Throughput: one event per cycle
//   at the output while pop is high; a snapshot of k events holds the queue
//   head until its last is loaded; the front takes one snapshot per cycle
//   while the queue has room. Reset clears the stored state to
//   "none recorded", empties the queue and the output stage. When the
//   receiver stalls, the output holds, the queue fills, and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module can_error_status_event_generator
   import cesg_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_action,
   input  wire logic               req_bus_off_flag,
   input  wire logic               req_passive_flag,
   input  wire logic               req_warning_flag,
   input  wire logic [CNT_W-1:0]   req_rx_error_count,
   input  wire logic [CNT_W-1:0]   req_tx_error_count,
   input  wire logic [LEC_W-1:0]   req_last_error_code,
   input  wire logic               req_transmitting,
   output logic                    empty,
   input  wire logic               pop,
   output logic [KIND_W-1:0]       rsp_event_kind,
   output logic [STATE_W-1:0]      rsp_bus_state,
   output logic [CNT_W-1:0]        rsp_rx_errors,
   output logic [CNT_W-1:0]        rsp_tx_errors,
   output logic                    rsp_error_in_tx,
   output logic [LEC_W-1:0]        rsp_error_kind,
   output logic                    rsp_last
);

   logic    accept;
   cmd_type cmd;
   logic    cmd_push;
   logic    q_full;
   cmd_type head;
   logic    head_valid;
   logic    head_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   cesg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_action),
      .bus_off_flag    (req_bus_off_flag),
      .passive_flag    (req_passive_flag),
      .warning_flag    (req_warning_flag),
      .rx_error_count  (req_rx_error_count),
      .tx_error_count  (req_tx_error_count),
      .last_error_code (req_last_error_code),
      .transmitting    (req_transmitting),
      .cmd             (cmd),
      .cmd_push        (cmd_push)
   );

   cesg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd),
      .full       (q_full),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   cesg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .head_pop        (head_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_bus_state   (rsp_bus_state),
      .rsp_rx_errors   (rsp_rx_errors),
      .rsp_tx_errors   (rsp_tx_errors),
      .rsp_error_in_tx (rsp_error_in_tx),
      .rsp_error_kind  (rsp_error_kind),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - CAN error status event generator testbench
// Feeds status snapshots and clear actions into the block, predicts the bus
// state, counter and bus-error events each one gives, and checks every event
// leaving the block against the oldest prediction, under random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cesg_pkg::*;

   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic               clr;
      logic               bus_off;
      logic               passive;
      logic               warning;
      logic [CNT_W-1:0]   rx;
      logic [CNT_W-1:0]   tx;
      logic [LEC_W-1:0]   lec;
      logic               txing;
   } snapshot_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [STATE_W-1:0] state;
      logic [CNT_W-1:0]   rx;
      logic [CNT_W-1:0]   tx;
      logic               in_tx;
      logic [LEC_W-1:0]   err_kind;
      logic               last;
   } can_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic               req_action = 1'b0;
   logic               req_bus_off_flag = 1'b0;
   logic               req_passive_flag = 1'b0;
   logic               req_warning_flag = 1'b0;
   logic [CNT_W-1:0]   req_rx_error_count = '0;
   logic [CNT_W-1:0]   req_tx_error_count = '0;
   logic [LEC_W-1:0]   req_last_error_code = '0;
   logic               req_transmitting = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic [KIND_W-1:0]  rsp_event_kind;
   logic [STATE_W-1:0] rsp_bus_state;
   logic [CNT_W-1:0]   rsp_rx_errors;
   logic [CNT_W-1:0]   rsp_tx_errors;
   logic               rsp_error_in_tx;
   logic [LEC_W-1:0]   rsp_error_kind;
   logic               rsp_last;

   can_error_status_event_generator uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_action          (req_action),
      .req_bus_off_flag    (req_bus_off_flag),
      .req_passive_flag    (req_passive_flag),
      .req_warning_flag    (req_warning_flag),
      .req_rx_error_count  (req_rx_error_count),
      .req_tx_error_count  (req_tx_error_count),
      .req_last_error_code (req_last_error_code),
      .req_transmitting    (req_transmitting),
      .empty               (empty),
      .pop                 (pop),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_bus_state       (rsp_bus_state),
      .rsp_rx_errors       (rsp_rx_errors),
      .rsp_tx_errors       (rsp_tx_errors),
      .rsp_error_in_tx     (rsp_error_in_tx),
      .rsp_error_kind      (rsp_error_kind),
      .rsp_last            (rsp_last)
   );

   always #4 clock = ~clock;

   snapshot_type   snapshot_queue[$];
   can_event_type  expected_events[$];
   snapshot_type   on_bus;
   int             queued_count = 0;
   int             accepted_count = 0;
   int             mismatches = 0;
   int             cycles = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_idle_pct = 0;

   // stored state of the predictor
   logic [STATE_W:0]   known_state = ST_NONE;
   logic [CNT_W-1:0]   known_rx = '0;
   logic [CNT_W-1:0]   known_tx = '0;

   // last values handed out by the stimulus generator
   logic [2:0]         gen_flags = '0;
   logic [CNT_W-1:0]   gen_rx = '0;
   logic [CNT_W-1:0]   gen_tx = '0;

   task automatic predict_events(input snapshot_type s);
      logic [STATE_W-1:0] now_state;
      can_event_type      evs[$];
      can_event_type      ev;
      if (s.clr) begin
         known_state = ST_NONE;
         known_rx    = '0;
         known_tx    = '0;
      end else begin
         if (s.bus_off)
            now_state = ST_BUSOFF;
         else if (s.passive)
            now_state = ST_PASSIVE;
         else if (s.warning)
            now_state = ST_WARNING;
         else
            now_state = ST_ACTIVE;
         if ({1'b0, now_state} != known_state) begin
            known_state = {1'b0, now_state};
            ev       = '0;
            ev.kind  = KIND_STATE;
            ev.state = now_state;
            evs.push_back(ev);
         end
         if (s.rx != known_rx || s.tx != known_tx) begin
            known_rx = s.rx;
            known_tx = s.tx;
            ev       = '0;
            ev.kind  = KIND_COUNTS;
            ev.rx    = s.rx;
            ev.tx    = s.tx;
            evs.push_back(ev);
         end
         // raw codes map one to one onto error kinds, top code is unknown
         if (s.lec != ERR_NONE) begin
            ev          = '0;
            ev.kind     = KIND_BUSERR;
            ev.in_tx    = s.txing;
            ev.err_kind = s.lec;
            evs.push_back(ev);
         end
         if (evs.size() > 0) begin
            ev      = evs.pop_back();
            ev.last = 1'b1;
            evs.push_back(ev);
         end
         foreach (evs[i])
            expected_events.push_back(evs[i]);
      end
   endtask

   task automatic report_failure(input string what, input can_event_type want,
                                 input can_event_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected kind=%0d st=%0d rx=%0d tx=%0d intx=%0d ek=%0d last=%0d",
                  $realtime, what, want.kind, want.state, want.rx, want.tx, want.in_tx,
                  want.err_kind, want.last);
         $display("   got kind=%0d st=%0d rx=%0d tx=%0d intx=%0d ek=%0d last=%0d",
                  got.kind, got.state, got.rx, got.tx, got.in_tx, got.err_kind, got.last);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (push) begin
            predict_events(on_bus);
            accepted_count++;
         end
         if (snapshot_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            on_bus = snapshot_queue.pop_front();
            push                <= 1'b1;
            req_action          <= on_bus.clr;
            req_bus_off_flag    <= on_bus.bus_off;
            req_passive_flag    <= on_bus.passive;
            req_warning_flag    <= on_bus.warning;
            req_rx_error_count  <= on_bus.rx;
            req_tx_error_count  <= on_bus.tx;
            req_last_error_code <= on_bus.lec;
            req_transmitting    <= on_bus.txing;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      can_event_type got;
      can_event_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_event_kind, rsp_bus_state, rsp_rx_errors, rsp_tx_errors,
                   rsp_error_in_tx, rsp_error_kind, rsp_last};
            if (expected_events.size() == 0) begin
               report_failure("unexpected event", '0, got);
            end else begin
               want = expected_events.pop_front();
               if (got !== want)
                  report_failure("event mismatch", want, got);
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("can_error_status_event_generator: mismatch");
         $finish;
      end
   end

   function automatic snapshot_type snap(input logic clr, input logic bo, input logic pa,
                                         input logic wa, input logic [CNT_W-1:0] rx,
                                         input logic [CNT_W-1:0] tx,
                                         input logic [LEC_W-1:0] lec, input logic txing);
      snapshot_type s;
      s = {clr, bo, pa, wa, rx, tx, lec, txing};
      return s;
   endfunction

   task automatic enqueue(input snapshot_type s);
      snapshot_queue.push_back(s);
      queued_count++;
   endtask

   function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] prev);
      logic [CNT_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = prev;
         4:          v = prev + 1'b1;
         5:          v = prev - 1'b1;
         6:          v = '1;
         7:          v = '0;
         default:    v = CNT_W'($urandom_range(255));
      endcase
      return v;
   endfunction

   task automatic add_random(input int n);
      snapshot_type s;
      for (int i = 0; i < n; i++) begin
         s.clr = ($urandom_range(15) == 0);
         if ($urandom_range(1) == 0)
            gen_flags = 3'($urandom_range(7));
         {s.bus_off, s.passive, s.warning} = gen_flags;
         gen_rx = next_count(gen_rx);
         gen_tx = next_count(gen_tx);
         s.rx   = gen_rx;
         s.tx   = gen_tx;
         s.lec  = ($urandom_range(1) == 0) ? ERR_NONE : LEC_W'($urandom_range(7));
         s.txing = 1'($urandom_range(1));
         enqueue(s);
      end
   endtask

   // wait until every queued snapshot is accepted and every expected event has been taken
   task automatic drain();
      while (accepted_count < queued_count || expected_events.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 75;

      // directed: first snapshot, no change, every error code, clears, counters
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   ERR_NONE,    1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   ERR_NONE,    1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b1, 8'd1,   8'd0,   ERR_STUFF,   1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b1, 1'b1, 8'd1,   8'd0,   ERR_FORM,    1'b1));
      enqueue(snap(1'b0, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, ERR_ACK,     1'b0));
      enqueue(snap(1'b0, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255, ERR_BIT1,    1'b0));
      enqueue(snap(1'b0, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255, ERR_BIT0,    1'b1));
      enqueue(snap(1'b0, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255, ERR_CRC,     1'b0));
      enqueue(snap(1'b0, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255, ERR_UNKNOWN, 1'b1));
      enqueue(snap(1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, ERR_UNKNOWN, 1'b1));
      enqueue(snap(1'b0, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255, ERR_NONE,    1'b0));
      enqueue(snap(1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   ERR_NONE,    1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   ERR_NONE,    1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd128, ERR_NONE,    1'b0));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 8'd128, ERR_NONE,    1'b1));
      enqueue(snap(1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0,   ERR_UNKNOWN, 1'b1));
      enqueue(snap(1'b0, 1'b0, 1'b1, 1'b0, 8'd0,   8'd0,   ERR_NONE,    1'b0));
      gen_rx = '0;
      gen_tx = '0;
      add_random(100);
      drain();

      send_idle_pct = 75;
      recv_idle_pct = 9;
      add_random(100);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(95);
      drain();
      repeat (16) @(posedge clock);

      if (mismatches == 0 && expected_events.size() == 0)
         $display("can_error_status_event_generator: match");
      else
         $display("can_error_status_event_generator: mismatch");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/cesg_pkg.sv
rtl/cesg_front.sv
rtl/cesg_queue.sv
rtl/cesg_back.sv
rtl/can_error_status_event_generator.sv
tb/tb_top.sv
